>>> hw/rtl/round_robin_task_scheduler_top_macros.svh
// Assertion macros used by the round-robin task scheduler datapath.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RRTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define RRTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rrts_pkg.sv
// Package for the round-robin task scheduler: sizes, codes and the
// command, status and result types. Depends on nothing.
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int STEP_W     = $clog2(SLOT_COUNT + 1);
   localparam int LIVE_W     = $clog2(SLOT_COUNT + 1);

   localparam int MODE_W  = 3;
   localparam int PTR_W   = 32;
   localparam int SIDX_W  = 4;
   localparam int ID_W    = 16;
   localparam int TICK_W  = 32;
   localparam int STATE_W = 2;
   localparam int RSLOT_W = 4;
   localparam int RLIVE_W = 5;

   localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESCHED = 3'd2;
   localparam logic [MODE_W-1:0] MODE_IRQ_RET = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

   localparam logic [STATE_W-1:0] ST_UNUSED     = 2'd0;
   localparam logic [STATE_W-1:0] ST_READY      = 2'd1;
   localparam logic [STATE_W-1:0] ST_RUNNING    = 2'd2;
   localparam logic [STATE_W-1:0] ST_TERMINATED = 2'd3;

   typedef struct packed {
      logic                 status;
      logic [PTR_W-1:0]     resume_pointer;
      logic                 switched;
      logic [ID_W-1:0]      created_id;
      logic [RSLOT_W-1:0]   running_slot;
      logic [ID_W-1:0]      running_id;
      logic [RLIVE_W-1:0]   live_count;
      logic [STATE_W-1:0]   slot_state;
      logic [TICK_W-1:0]    slot_ticks;
      logic [ID_W-1:0]      slot_id;
   } rsp_payload_type;

   typedef struct packed {
      logic in_ready;
      logic exec_exit;
      logic exec_resched;
      logic create_fill;
      logic create_full;
      logic scan_next;
      logic irq_resume;
      logic irq_save;
      logic irq_pick;
      logic irq_none;
      logic irq_load;
      logic read_load;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic              req_valid;
      logic [MODE_W-1:0] mode;
      logic              slot_free;
      logic              addr_last;
      logic              runnable;
      logic              steps_done;
      logic              irq_switch_ok;
      logic              out_free;
   } ctl_status_type;

endpackage

>>> hw/rtl/rrts_ifs.sv
// Request and response channel interfaces of the task scheduler.
// Depends on rrts_pkg for the field widths.
`timescale 1ns / 1ps

interface rrts_req_if;
   import rrts_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [PTR_W-1:0]  context_pointer;
   logic [SIDX_W-1:0] slot_index;

   modport source (output valid, mode, context_pointer, slot_index, input ready);
   modport sink (input valid, mode, context_pointer, slot_index, output ready);
endinterface

interface rrts_rsp_if;
   import rrts_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [PTR_W-1:0]   resume_pointer;
   logic               switched;
   logic [ID_W-1:0]    created_id;
   logic [RSLOT_W-1:0] running_slot;
   logic [ID_W-1:0]    running_id;
   logic [RLIVE_W-1:0] live_count;
   logic [STATE_W-1:0] slot_state;
   logic [TICK_W-1:0]  slot_ticks;
   logic [ID_W-1:0]    slot_id;

   modport source (output valid, status, resume_pointer, switched, created_id,
                   running_slot, running_id, live_count, slot_state, slot_ticks,
                   slot_id, input ready);
   modport sink (input valid, status, resume_pointer, switched, created_id,
                 running_slot, running_id, live_count, slot_state, slot_ticks,
                 slot_id, output ready);
endinterface

>>> hw/rtl/rrts_ctrl.sv
// Sequencing state machine of the task scheduler.
// Depends on rrts_pkg; drives the datapath through command signals only.
`timescale 1ns / 1ps

module rrts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  rrts_pkg::ctl_status_type sts,
   output rrts_pkg::ctl_cmd_type    cmd
);
   import rrts_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE        = 7'b0000001,
      S_DISPATCH    = 7'b0000010,
      S_CREATE_SCAN = 7'b0000100,
      S_IRQ_SCAN    = 7'b0001000,
      S_IRQ_LOAD    = 7'b0010000,
      S_READ_LOAD   = 7'b0100000,
      S_FINISH      = 7'b1000000
   } fsm_type;

   fsm_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (sts.req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.mode)
               MODE_CREATE: begin
                  state_in = S_CREATE_SCAN;
               end
               MODE_EXIT: begin
                  cmd.exec_exit = 1'b1;
                  state_in      = S_FINISH;
               end
               MODE_RESCHED: begin
                  cmd.exec_resched = 1'b1;
                  state_in         = S_FINISH;
               end
               MODE_IRQ_RET: begin
                  cmd.irq_resume = 1'b1;
                  if (sts.irq_switch_ok) begin
                     cmd.irq_save = 1'b1;
                     state_in     = S_IRQ_SCAN;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               MODE_READ: begin
                  state_in = S_READ_LOAD;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_CREATE_SCAN: begin
            if (sts.slot_free) begin
               cmd.create_fill = 1'b1;
               state_in        = S_FINISH;
            end else if (sts.addr_last) begin
               cmd.create_full = 1'b1;
               state_in        = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_IRQ_SCAN: begin
            if (sts.runnable) begin
               cmd.irq_pick = 1'b1;
               state_in     = S_IRQ_LOAD;
            end else if (sts.steps_done) begin
               cmd.irq_none = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_IRQ_LOAD: begin
            cmd.irq_load = 1'b1;
            state_in     = S_FINISH;
         end
         S_READ_LOAD: begin
            cmd.read_load = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // The result waits here until the output register is free.
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/rrts_dpath.sv
// Datapath of the task scheduler: slot table, pointer, id and tick memories,
// scheduler registers and the output register. Depends on rrts_pkg.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_top_macros.svh"

module rrts_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  rrts_pkg::ctl_cmd_type    cmd,
   output rrts_pkg::ctl_status_type sts,
   rrts_req_if.sink                 req_if,
   rrts_rsp_if.source               rsp_if
);
   import rrts_pkg::*;

   function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v);
      logic [SLOT_W-1:0] r;
      if (v == SLOT_W'(SLOT_COUNT - 1)) begin
         r = '0;
      end else begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   // Scheduler state.
   logic [STATE_W-1:0] slot_st_ff [SLOT_COUNT];
   logic [STATE_W-1:0] slot_st_in [SLOT_COUNT];
   logic               cnt_vld_ff [SLOT_COUNT];
   logic               cnt_vld_in [SLOT_COUNT];
   logic [SLOT_W-1:0]  run_idx_ff, run_idx_in;
   logic [ID_W-1:0]    run_id_ff, run_id_in;
   logic [LIVE_W-1:0]  live_ff, live_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic               pend_ff, pend_in;

   // Scan address and step count.
   logic [SLOT_W-1:0]  addr_ff, addr_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // Item being worked on and its partial result.
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [SIDX_W-1:0]  sidx_ff, sidx_in;
   logic               status_ff, status_in;
   logic [PTR_W-1:0]   resume_ff, resume_in;
   logic               switched_ff, switched_in;
   logic [ID_W-1:0]    created_ff, created_in;
   logic [STATE_W-1:0] rd_state_ff, rd_state_in;
   logic [TICK_W-1:0]  rd_ticks_ff, rd_ticks_in;
   logic [ID_W-1:0]    rd_id_ff, rd_id_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   // Memories with registered reads at the scan address.
   logic [PTR_W-1:0]   ptr_mem [SLOT_COUNT];
   logic [ID_W-1:0]    id_mem [SLOT_COUNT];
   logic [TICK_W-1:0]  cnt_mem [SLOT_COUNT];
   logic [PTR_W-1:0]   ptr_rd_ff;
   logic [ID_W-1:0]    id_rd_ff;
   logic [TICK_W-1:0]  cnt_rd_ff;
   logic               ptr_we;
   logic [SLOT_W-1:0]  ptr_waddr;
   logic               cnt_we;
   logic [TICK_W-1:0]  cnt_base;

   logic               req_fire;
   logic               out_free;
   logic [STATE_W-1:0] cur_st;
   logic               runnable;

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign cur_st   = slot_st_ff[addr_ff];
   assign runnable = (cur_st == ST_READY) || (cur_st == ST_RUNNING);
   assign cnt_base = cnt_vld_ff[addr_ff] ? cnt_rd_ff : '0;

   assign sts.req_valid     = req_if.valid;
   assign sts.mode          = mode_ff;
   assign sts.slot_free     = (cur_st == ST_UNUSED);
   assign sts.addr_last     = (addr_ff == SLOT_W'(SLOT_COUNT - 1));
   assign sts.runnable      = runnable;
   assign sts.steps_done    = (step_ff == STEP_W'(SLOT_COUNT));
   assign sts.irq_switch_ok = pend_ff && (live_ff > LIVE_W'(1));
   assign sts.out_free      = out_free;

   assign ptr_we    = cmd.create_fill || cmd.irq_save;
   assign ptr_waddr = cmd.irq_save ? run_idx_ff : addr_ff;
   assign cnt_we    = cmd.irq_load;

   always_comb begin
      slot_st_in   = slot_st_ff;
      cnt_vld_in   = cnt_vld_ff;
      run_idx_in   = run_idx_ff;
      run_id_in    = run_id_ff;
      live_in      = live_ff;
      next_id_in   = next_id_ff;
      pend_in      = pend_ff;
      addr_in      = addr_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      ptr_in       = ptr_ff;
      sidx_in      = sidx_ff;
      status_in    = status_ff;
      resume_in    = resume_ff;
      switched_in  = switched_ff;
      created_in   = created_ff;
      rd_state_in  = rd_state_ff;
      rd_ticks_in  = rd_ticks_ff;
      rd_id_in     = rd_id_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (req_fire) begin
         mode_in     = req_if.mode;
         ptr_in      = req_if.context_pointer;
         sidx_in     = req_if.slot_index;
         status_in   = 1'b0;
         resume_in   = '0;
         switched_in = 1'b0;
         created_in  = '0;
         rd_state_in = '0;
         rd_ticks_in = '0;
         rd_id_in    = '0;
         step_in     = '0;
         // A read addresses its slot directly; create scans from slot 1.
         if (req_if.mode == MODE_READ) begin
            addr_in = SLOT_W'(req_if.slot_index);
         end else begin
            addr_in = SLOT_W'(1);
         end
      end

      if (cmd.exec_exit) begin
         if (run_idx_ff != '0) begin
            slot_st_in[run_idx_ff] = ST_TERMINATED;
            if (live_ff != '0) begin
               live_in = live_ff - 1'b1;
            end
         end
         pend_in = 1'b1;
      end

      if (cmd.exec_resched) begin
         pend_in = 1'b1;
      end

      if (cmd.create_fill) begin
         slot_st_in[addr_ff] = ST_READY;
         cnt_vld_in[addr_ff] = 1'b0;
         next_id_in          = next_id_ff + 1'b1;
         live_in             = live_ff + 1'b1;
         created_in          = next_id_ff;
      end

      if (cmd.create_full) begin
         status_in = 1'b1;
      end

      if (cmd.scan_next) begin
         addr_in = wrap_inc(addr_ff);
         step_in = step_ff + 1'b1;
      end

      if (cmd.irq_resume) begin
         resume_in = ptr_ff;
         pend_in   = 1'b0;
      end

      if (cmd.irq_save) begin
         // The running task is demoted so that the scan may pick it again.
         if (slot_st_ff[run_idx_ff] == ST_RUNNING) begin
            slot_st_in[run_idx_ff] = ST_READY;
         end
         addr_in = wrap_inc(run_idx_ff);
         step_in = STEP_W'(1);
      end

      if (cmd.irq_pick) begin
         slot_st_in[addr_ff] = ST_RUNNING;
         switched_in         = (addr_ff != run_idx_ff);
         run_idx_in          = addr_ff;
      end

      if (cmd.irq_none) begin
         slot_st_in[run_idx_ff] = ST_RUNNING;
      end

      if (cmd.irq_load) begin
         resume_in           = ptr_rd_ff;
         cnt_vld_in[addr_ff] = 1'b1;
         if (addr_ff == '0) begin
            run_id_in = '0;
         end else begin
            run_id_in = id_rd_ff;
         end
      end

      if (cmd.read_load) begin
         if (int'(sidx_ff) < SLOT_COUNT) begin
            rd_state_in = cur_st;
            rd_ticks_in = cnt_base;
            if (addr_ff == '0) begin
               rd_id_in = '0;
            end else begin
               rd_id_in = id_rd_ff;
            end
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = status_ff;
         rsp_data_in.resume_pointer  = resume_ff;
         rsp_data_in.switched        = switched_ff;
         rsp_data_in.created_id      = created_ff;
         rsp_data_in.running_slot    = RSLOT_W'(run_idx_ff);
         rsp_data_in.running_id      = run_id_ff;
         rsp_data_in.live_count      = RLIVE_W'(live_ff);
         rsp_data_in.slot_state      = rd_state_ff;
         rsp_data_in.slot_ticks      = rd_ticks_ff;
         rsp_data_in.slot_id         = rd_id_ff;
      end else if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_st_ff[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
            cnt_vld_ff[i] <= 1'b0;
         end
         run_idx_ff   <= '0;
         run_id_ff    <= '0;
         live_ff      <= LIVE_W'(1);
         next_id_ff   <= ID_W'(1);
         pend_ff      <= 1'b0;
         addr_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_st_ff   <= slot_st_in;
         cnt_vld_ff   <= cnt_vld_in;
         run_idx_ff   <= run_idx_in;
         run_id_ff    <= run_id_in;
         live_ff      <= live_in;
         next_id_ff   <= next_id_in;
         pend_ff      <= pend_in;
         addr_ff      <= addr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      ptr_ff      <= ptr_in;
      sidx_ff     <= sidx_in;
      status_ff   <= status_in;
      resume_ff   <= resume_in;
      switched_ff <= switched_in;
      created_ff  <= created_in;
      rd_state_ff <= rd_state_in;
      rd_ticks_ff <= rd_ticks_in;
      rd_id_ff    <= rd_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_waddr] <= ptr_ff;
      end
      ptr_rd_ff <= ptr_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.create_fill) begin
         id_mem[addr_ff] <= next_id_ff;
      end
      id_rd_ff <= id_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[addr_ff] <= cnt_base + 1'b1;
      end
      cnt_rd_ff <= cnt_mem[addr_ff];
   end

   assign req_if.ready = cmd.in_ready;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_data_ff.status;
   assign rsp_if.resume_pointer = rsp_data_ff.resume_pointer;
   assign rsp_if.switched       = rsp_data_ff.switched;
   assign rsp_if.created_id     = rsp_data_ff.created_id;
   assign rsp_if.running_slot   = rsp_data_ff.running_slot;
   assign rsp_if.running_id     = rsp_data_ff.running_id;
   assign rsp_if.live_count     = rsp_data_ff.live_count;
   assign rsp_if.slot_state     = rsp_data_ff.slot_state;
   assign rsp_if.slot_ticks     = rsp_data_ff.slot_ticks;
   assign rsp_if.slot_id        = rsp_data_ff.slot_id;

   `RRTS_ASSERT(a_idle_slot_alive, clock, reset, slot_st_ff[0] == ST_RUNNING || slot_st_ff[0] == ST_READY, "idle slot left the runnable states")
   `RRTS_ASSERT(a_live_bound, clock, reset, live_ff <= LIVE_W'(SLOT_COUNT), "live count exceeds the slot count")
   `RRTS_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.out_load, out_free, "result loaded over an untaken item")
   `RRTS_ASSERT_IMPLY(a_pick_runnable, clock, reset, cmd.irq_pick, runnable, "scheduler picked a slot that is not runnable")

endmodule

>>> hw/rtl/round_robin_task_scheduler_top.sv
// Sequence: exit, reschedule and unknown modes go from dispatch to the finish state;
// a slot read passes through the read load state; create scans for a free slot, one slot per cycle;
// interrupt return goes to the finish state, or when it reschedules scans one slot per scan cycle
// and then loads the chosen task. The controller holds one item at a time.
// Reset: synchronous, active high; slot 0 running, others unused, tick counts zero.
`timescale 1ns / 1ps

module round_robin_task_scheduler_top (
   input logic        clock,
   input logic        reset,
   rrts_req_if.sink   req_if,
   rrts_rsp_if.source rsp_if
);
   import rrts_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type sts;

   rrts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   rrts_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

>>> tb/round_robin_task_scheduler_top_tb.sv
// Self-checking testbench for the round-robin task scheduler top level.
// Depends on rrts_pkg, the rrts_req_if and rrts_rsp_if interfaces and the top module.
`timescale 1ns / 1ps

module round_robin_task_scheduler_top_tb;
   import rrts_pkg::*;

   localparam int RANDOM_CALLS = 1150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [PTR_W-1:0] PTR_MAX = '1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PTR_W-1:0]  context_pointer;
      logic [SIDX_W-1:0] slot_index;
   } sched_call_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrts_req_if req_bus ();
   rrts_rsp_if rsp_bus ();

   round_robin_task_scheduler_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #5 clock = ~clock;

   // Shadow copy of the task table.
   logic [STATE_W-1:0] tbl_state [SLOT_COUNT];
   logic [PTR_W-1:0]   tbl_ptr   [SLOT_COUNT];
   logic [ID_W-1:0]    tbl_id    [SLOT_COUNT];
   logic [TICK_W-1:0]  tbl_ticks [SLOT_COUNT];
   int                 run_slot;
   int                 live_tasks;
   logic [ID_W-1:0]    next_id;
   bit                 resched_flag;

   sched_call_type  sched_calls[$];
   rsp_payload_type answers_due[$];

   sched_call_type cur_call;
   int          n_queued;
   int          n_accepted;
   int          n_checked;
   int          n_switches;
   int          n_full;
   int          errors;
   int          burst_left;
   int          gap_left;
   int          rx_hold;
   logic [31:0] rx_cycle;
   int          quiet;
   int          made;

   task automatic table_reset();
      for (int k = 0; k < SLOT_COUNT; k++) begin
         tbl_state[k] = ST_UNUSED;
         tbl_ptr[k]   = '0;
         tbl_id[k]    = '0;
         tbl_ticks[k] = '0;
      end
      tbl_state[0] = ST_RUNNING;
      run_slot     = 0;
      live_tasks   = 1;
      next_id      = 1;
      resched_flag = 0;
   endtask

   // Applies one call to the shadow table and returns the answer it should get.
   task automatic advance_task_table(input sched_call_type c, output rsp_payload_type r);
      bit found;
      int cur;
      int idx;
      int nxt;
      r = '0;
      found = 0;
      nxt = 0;
      case (c.mode)
         MODE_CREATE: begin
            for (int k = 1; k < SLOT_COUNT; k++) begin
               if (!found && tbl_state[k] == ST_UNUSED) begin
                  found        = 1;
                  tbl_id[k]    = next_id;
                  next_id      = next_id + 1'b1;
                  tbl_state[k] = ST_READY;
                  tbl_ticks[k] = '0;
                  tbl_ptr[k]   = c.context_pointer;
                  live_tasks++;
                  r.created_id = tbl_id[k];
               end
            end
            if (!found) r.status = 1'b1;
         end
         MODE_EXIT: begin
            if (run_slot != 0) begin
               tbl_state[run_slot] = ST_TERMINATED;
               if (live_tasks > 0) live_tasks--;
            end
            resched_flag = 1;
         end
         MODE_RESCHED: resched_flag = 1;
         MODE_IRQ_RET: begin
            r.resume_pointer = c.context_pointer;
            if (resched_flag) begin
               resched_flag = 0;
               if (live_tasks > 1) begin
                  cur = run_slot;
                  tbl_ptr[cur] = c.context_pointer;
                  if (tbl_state[cur] == ST_RUNNING) tbl_state[cur] = ST_READY;
                  for (int k = 1; k <= SLOT_COUNT; k++) begin
                     idx = (cur + k) % SLOT_COUNT;
                     if (!found && (tbl_state[idx] == ST_READY ||
                                    tbl_state[idx] == ST_RUNNING)) begin
                        found = 1;
                        nxt   = idx;
                     end
                  end
                  if (!found) begin
                     tbl_state[cur] = ST_RUNNING;
                  end else begin
                     tbl_state[nxt]   = ST_RUNNING;
                     tbl_ticks[nxt]   = tbl_ticks[nxt] + 1'b1;
                     run_slot         = nxt;
                     r.resume_pointer = tbl_ptr[nxt];
                     r.switched       = (nxt != cur);
                  end
               end
            end
         end
         MODE_READ: begin
            if (c.slot_index < SLOT_COUNT) begin
               r.slot_state = tbl_state[c.slot_index];
               r.slot_ticks = tbl_ticks[c.slot_index];
               r.slot_id    = tbl_id[c.slot_index];
            end
         end
         default: ;
      endcase
      r.running_slot = RSLOT_W'(run_slot);
      r.running_id   = tbl_id[run_slot];
      r.live_count   = RLIVE_W'(live_tasks);
   endtask

   task automatic queue_call(input logic [MODE_W-1:0] mode, input logic [PTR_W-1:0] ptr,
                             input logic [SIDX_W-1:0] sidx);
      sched_call_type c;
      c.mode            = mode;
      c.context_pointer = ptr;
      c.slot_index      = sidx;
      sched_calls.push_back(c);
      n_queued++;
      // Slots are filled in order and never reused, so the written ones form a prefix.
      if (mode == MODE_CREATE && made < SLOT_COUNT - 1) made++;
   endtask

   function automatic logic [PTR_W-1:0] pick_pointer();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return PTR_MAX;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SIDX_W-1:0] any_slot();
      return SIDX_W'($urandom_range(0, (1 << SIDX_W) - 1));
   endfunction

   task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                              input logic [TICK_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.mode            = MODE_READ;
      req_bus.context_pointer = '0;
      req_bus.slot_index      = '0;
      rsp_bus.ready           = 1'b0;
   end

   // Driver: items go out in bursts with idle gaps in between.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            rsp_payload_type want;
            advance_task_table(cur_call, want);
            answers_due.push_back(want);
            n_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (sched_calls.size() > 0) begin
               cur_call = sched_calls.pop_front();
               req_bus.valid           <= 1'b1;
               req_bus.mode            <= cur_call.mode;
               req_bus.context_pointer <= cur_call.context_pointer;
               req_bus.slot_index      <= cur_call.slot_index;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: the stall style is chosen by bits 9:8 of a free-running cycle counter.
   always @(posedge clock) begin
      rx_cycle++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_hold = 0;
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rx_cycle[9:8])
            2'd0: rsp_bus.ready <= 1'b1;
            2'd1: rsp_bus.ready <= (rx_cycle[1:0] != 2'b00);
            2'd2: begin
               if ($urandom_range(0, 5) == 0) begin
                  rx_hold = $urandom_range(1, 14);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
            default: rsp_bus.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // Monitor: every item on the response channel is checked against the oldest answer due.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (answers_due.size() == 0) begin
            $error("response item arrived with no call outstanding");
            errors++;
         end else begin
            rsp_payload_type want;
            want = answers_due.pop_front();
            check_field("status",         want.status,         rsp_bus.status);
            check_field("resume_pointer", want.resume_pointer, rsp_bus.resume_pointer);
            check_field("switched",       want.switched,       rsp_bus.switched);
            check_field("created_id",     want.created_id,     rsp_bus.created_id);
            check_field("running_slot",   want.running_slot,   rsp_bus.running_slot);
            check_field("running_id",     want.running_id,     rsp_bus.running_id);
            check_field("live_count",     want.live_count,     rsp_bus.live_count);
            check_field("slot_state",     want.slot_state,     rsp_bus.slot_state);
            check_field("slot_ticks",     want.slot_ticks,     rsp_bus.slot_ticks);
            check_field("slot_id",        want.slot_id,        rsp_bus.slot_id);
            n_checked++;
            if (want.switched) n_switches++;
            if (want.status) n_full++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("Timed out: no item moved for %0d cycles", QUIET_LIMIT);
         $display("round_robin_task_scheduler_top_tb: errors");
         $finish;
      end
   end

   initial begin
      int pick;
      rx_cycle   = '0;
      quiet      = 0;
      errors     = 0;
      n_queued   = 0;
      n_accepted = 0;
      n_checked  = 0;
      n_switches = 0;
      n_full     = 0;
      made       = 0;
      table_reset();

      // Directed opening: idle-only behaviour and unknown modes first, then creates, a few switches and an exit.
      queue_call(MODE_READ,    '0,      '0);
      queue_call(MODE_IRQ_RET, '0,      any_slot());
      queue_call(MODE_RESCHED, PTR_MAX, '1);
      queue_call(MODE_IRQ_RET, PTR_MAX, '0);
      queue_call(MODE_EXIT,    '0,      '1);
      for (int k = 1; k <= 3; k++)
         queue_call(MODE_READ + k[MODE_W-1:0], PTR_MAX, '1);
      queue_call(MODE_CREATE,  '0,           any_slot());
      queue_call(MODE_CREATE,  PTR_MAX,      any_slot());
      queue_call(MODE_CREATE,  32'hA5A5A5A5, any_slot());
      queue_call(MODE_READ,    $urandom,     SIDX_W'(1));
      queue_call(MODE_READ,    $urandom,     SIDX_W'(3));
      queue_call(MODE_RESCHED, $urandom,     any_slot());
      queue_call(MODE_IRQ_RET, 32'h12345678, any_slot());
      queue_call(MODE_IRQ_RET, 32'h5A5A5A5A, any_slot());
      queue_call(MODE_RESCHED, $urandom,     any_slot());
      queue_call(MODE_IRQ_RET, $urandom,     any_slot());
      queue_call(MODE_EXIT,    $urandom,     any_slot());
      queue_call(MODE_IRQ_RET, $urandom,     any_slot());
      queue_call(MODE_READ,    $urandom,     SIDX_W'(2));
      queue_call(MODE_RESCHED, $urandom,     any_slot());
      queue_call(MODE_IRQ_RET, pick_pointer(), any_slot());
      queue_call(MODE_READ,    $urandom,     '0);

      // Random part: mostly reschedule and interrupt-return pairs and slot reads, with exits kept rare
      // so that the table does not drain to the idle task too early.
      while (n_queued < RANDOM_CALLS + 25) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            queue_call(MODE_CREATE, pick_pointer(), any_slot());
         end else if (pick < 12) begin
            queue_call(MODE_EXIT, pick_pointer(), any_slot());
            if ($urandom_range(0, 4) != 0)
               queue_call(MODE_IRQ_RET, pick_pointer(), any_slot());
         end else if (pick < 45) begin
            queue_call(MODE_RESCHED, pick_pointer(), any_slot());
            queue_call(MODE_IRQ_RET, pick_pointer(), any_slot());
         end else if (pick < 55) begin
            queue_call(MODE_IRQ_RET, pick_pointer(), any_slot());
         end else if (pick < 60) begin
            queue_call(MODE_RESCHED, pick_pointer(), any_slot());
         end else if (pick < 96) begin
            queue_call(MODE_READ, pick_pointer(), SIDX_W'($urandom_range(0, made)));
         end else begin
            queue_call(MODE_READ + MODE_W'($urandom_range(1, 3)), pick_pointer(), any_slot());
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < n_queued) @(posedge clock);
      while (answers_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d calls and checked %0d responses, covering %0d task switches",
               n_accepted, n_checked, n_switches);
      $display("and %0d creates refused on a full table.", n_full);
      if (errors == 0 && answers_due.size() == 0) begin
         $display("round_robin_task_scheduler_top_tb: clean");
      end else begin
         $display("round_robin_task_scheduler_top_tb: errors");
      end
      $finish;
   end

endmodule
